[hdl/mat_pkg.sv]
// Shared types and constants for the multiturn angle tracker.
// No dependencies; imported by mat_reply and multiturn_angle_tracker_top.
package mat_pkg;

    localparam int unsigned ANGLE_W = 16;
    localparam int unsigned CONT_W  = 32;
    localparam int unsigned SHIFT_W = 5;

    localparam logic [2:0] CFG_POLE_PAIRS   = 3'd0;
    localparam logic [2:0] CFG_ELEC_OFFSET  = 3'd1;
    localparam logic [2:0] CFG_START_ANGLE  = 3'd2;
    localparam logic [2:0] CFG_QUERY_CODE   = 3'd3;
    localparam logic [2:0] CFG_COMMAND_MASK = 3'd4;

    localparam logic [15:0] ANGLE_BIAS   = 16'd16384;
    localparam logic [15:0] WRAP_LOW     = 16'd8192;
    localparam logic [15:0] WRAP_HIGH    = 16'd24576;
    localparam logic [31:0] TURN_STEP    = 32'd32768;
    localparam logic [12:0] SPEED_SCALE  = 13'd6000;
    localparam int unsigned SPEED_SHIFT  = 15;
    localparam logic [6:0]  RATE_SCALE   = 7'd100;
    localparam logic [4:0]  SHIFT_MAX    = 5'd24;
    localparam logic [4:0]  SHIFT_RESET  = 5'd7;
    localparam logic [4:0]  UPPER_OFFSET = 5'd7;
    localparam logic [7:0]  TERMINATOR   = 8'd128;
    localparam int unsigned MARK_BIT     = 7;

    typedef struct packed {
        logic [6:0] query_code;
        logic [6:0] mask;
    } t_cmd_cfg;

    typedef struct packed {
        logic       valid;
        logic [6:0] upper;
        logic [6:0] lower;
        logic [6:0] checksum;
        logic [7:0] terminator;
    } t_reply;

endpackage

[hdl/mat_reply.sv]
// Command byte decode, reply shift update and position reply bytes.
// Depends on mat_pkg.
module mat_reply (
    input  logic                 i_cmd_valid,
    input  logic [7:0]           i_rx_first,
    input  logic [7:0]           i_rx_second,
    input  logic [7:0]           i_rx_third,
    input  mat_pkg::t_cmd_cfg    i_cfg,
    input  logic [4:0]           i_shift,
    input  logic [31:0]          i_continuous,
    output logic [4:0]           o_shift,
    output mat_pkg::t_reply      o_reply
);
    import mat_pkg::*;

    logic [6:0]  code;
    logic [13:0] raw;
    logic [4:0]  up_amt;
    logic [31:0] up_full;
    logic [31:0] lo_full;
    logic [6:0]  sum;

    always_comb begin
        priority if (i_rx_first[MARK_BIT]) begin
            code = i_rx_first[6:0] & i_cfg.mask;
            raw  = {i_rx_second[6:0], i_rx_third[6:0]} | {6'd0, i_rx_third[MARK_BIT], 7'd0};
        end else if (i_rx_second[MARK_BIT]) begin
            code = i_rx_second[6:0] & i_cfg.mask;
            raw  = {i_rx_third[6:0], i_rx_first[6:0]};
        end else begin
            code = i_rx_third[6:0] & i_cfg.mask;
            raw  = {i_rx_first[6:0], i_rx_second[6:0]};
        end
    end

    always_comb begin
        o_shift = i_shift;
        if (i_cmd_valid && (code == i_cfg.query_code)) begin
            priority if (raw[13]) begin
                o_shift = 5'd0;
            end else if (raw[12:0] > 13'(SHIFT_MAX)) begin
                o_shift = SHIFT_MAX;
            end else begin
                o_shift = raw[4:0];
            end
        end
    end

    assign up_amt  = o_shift + UPPER_OFFSET;
    assign up_full = $signed(i_continuous) >>> up_amt;
    assign lo_full = $signed(i_continuous) >>> o_shift;
    assign sum     = up_full[6:0] + lo_full[6:0];

    always_comb begin
        o_reply = '0;
        if (i_cmd_valid) begin
            o_reply.valid      = 1'b1;
            o_reply.upper      = up_full[6:0];
            o_reply.lower      = lo_full[6:0];
            o_reply.checksum   = sum;
            o_reply.terminator = TERMINATOR;
        end
    end

endmodule

[hdl/multiturn_angle_tracker_top.sv]
// Top level of the multiturn angle tracker: input register, state update and result register.
// Depends on mat_pkg and mat_reply.
//
// Each accepted transaction is one control loop. It is registered on acceptance, processed
// in a single pass against the tracker state and then lands in the result register. One
// transaction can be accepted every cycle while the result register is empty or being read
// (the input register refills while the result register drains). The mechanical angle
// is the shift-FILTER_SHIFT accumulator output taken before the new sample is added. Wraps of
// the filtered angle keep a turn offset for the continuous angle; a command produces a
// four-byte position reply and a tick latches speed and loop rate. There is no clearing
// pass after reset; configuration writes take effect on the next cycle.
module multiturn_angle_tracker_top #(
    parameter int unsigned FILTER_SHIFT = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_sensor_high,
    input  logic [7:0]  i_sensor_low,
    input  logic        i_command_valid,
    input  logic [7:0]  i_rx_first,
    input  logic [7:0]  i_rx_second,
    input  logic [7:0]  i_rx_third,
    input  logic        i_tick,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [14:0] o_electrical_angle,
    output logic signed [31:0] o_continuous_angle,
    output logic signed [31:0] o_speed_rpm,
    output logic        o_reply_valid,
    output logic [6:0]  o_reply_upper,
    output logic [6:0]  o_reply_lower,
    output logic [6:0]  o_reply_checksum,
    output logic [7:0]  o_reply_terminator,
    output logic [15:0] o_loop_rate
);
    import mat_pkg::*;

    localparam int unsigned SUM_W = 17 + FILTER_SHIFT;

    logic [5:0]  r_pole_pairs;
    logic [14:0] r_elec_offset;
    t_cmd_cfg    r_cmd_cfg;

    logic        r_in_vld;
    logic [7:0]  r_sensor_high;
    logic [7:0]  r_sensor_low;
    logic        r_command_valid;
    logic [7:0]  r_rx_first;
    logic [7:0]  r_rx_second;
    logic [7:0]  r_rx_third;
    logic        r_tick;

    logic [SUM_W-1:0] r_filter_sum;
    logic [15:0] r_prev_angle;
    logic [31:0] r_turn_offset;
    logic [31:0] r_last_cont;
    logic [31:0] r_speed_hold;
    logic [15:0] r_loop_counter;
    logic [15:0] r_rate_hold;
    logic [4:0]  r_reply_shift;

    logic        r_out_vld;
    logic [14:0] r_elec;
    logic [31:0] r_cont;
    t_reply      r_reply;

    logic             advance;
    logic [15:0]      sample;
    logic [15:0]      angle;
    logic [SUM_W-1:0] n_filter_sum;
    logic [20:0]      elec_prod;
    logic [14:0]      n_elec;
    logic [31:0]      n_turn_offset;
    logic [31:0]      n_cont;
    logic [4:0]       n_reply_shift;
    t_reply           n_reply;
    logic [31:0]      cont_diff;
    logic [44:0]      speed_prod;
    logic [31:0]      speed_shr;
    logic [15:0]      loop_next;
    logic [22:0]      rate_prod;

    assign advance    = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || advance;

    assign sample       = {r_sensor_high, r_sensor_low} + ANGLE_BIAS;
    assign angle        = r_filter_sum[FILTER_SHIFT +: ANGLE_W];
    assign n_filter_sum = r_filter_sum - SUM_W'(angle) + SUM_W'(sample);

    assign elec_prod = angle[14:0] * r_pole_pairs;
    assign n_elec    = elec_prod[14:0] - r_elec_offset;

    always_comb begin
        priority if ((r_prev_angle < WRAP_LOW) && (angle > WRAP_HIGH)) begin
            n_turn_offset = r_turn_offset - TURN_STEP;
        end else if ((angle < WRAP_LOW) && (r_prev_angle > WRAP_HIGH)) begin
            n_turn_offset = r_turn_offset + TURN_STEP;
        end else begin
            n_turn_offset = r_turn_offset;
        end
    end

    assign n_cont = {16'd0, angle} + n_turn_offset;

    mat_reply u_reply (
        .i_cmd_valid  (r_command_valid),
        .i_rx_first   (r_rx_first),
        .i_rx_second  (r_rx_second),
        .i_rx_third   (r_rx_third),
        .i_cfg        (r_cmd_cfg),
        .i_shift      (r_reply_shift),
        .i_continuous (n_cont),
        .o_shift      (n_reply_shift),
        .o_reply      (n_reply)
    );

    assign cont_diff  = n_cont - r_last_cont;
    assign speed_prod = cont_diff * SPEED_SCALE;
    assign speed_shr  = $signed(speed_prod[31:0]) >>> SPEED_SHIFT;
    assign loop_next  = r_loop_counter + 16'd1;
    assign rate_prod  = loop_next * RATE_SCALE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pole_pairs       <= 6'd1;
            r_elec_offset      <= '0;
            r_cmd_cfg.query_code <= '0;
            r_cmd_cfg.mask     <= 7'h7F;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_POLE_PAIRS:   r_pole_pairs         <= i_cfg_data[5:0];
                CFG_ELEC_OFFSET:  r_elec_offset        <= i_cfg_data[14:0];
                CFG_QUERY_CODE:   r_cmd_cfg.query_code <= i_cfg_data[6:0];
                CFG_COMMAND_MASK: r_cmd_cfg.mask       <= i_cfg_data[6:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_sensor_high   <= i_sensor_high;
            r_sensor_low    <= i_sensor_low;
            r_command_valid <= i_command_valid;
            r_rx_first      <= i_rx_first;
            r_rx_second     <= i_rx_second;
            r_rx_third      <= i_rx_third;
            r_tick          <= i_tick;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_sum   <= '0;
            r_prev_angle   <= '0;
            r_turn_offset  <= '0;
            r_last_cont    <= '0;
            r_speed_hold   <= '0;
            r_loop_counter <= '0;
            r_rate_hold    <= '0;
            r_reply_shift  <= SHIFT_RESET;
        end else begin
            if (i_cfg_we && (i_cfg_index == CFG_START_ANGLE)) begin
                r_prev_angle <= i_cfg_data;
            end else if (advance) begin
                r_prev_angle <= angle;
            end
            if (advance) begin
                r_filter_sum  <= n_filter_sum;
                r_turn_offset <= n_turn_offset;
                r_reply_shift <= n_reply_shift;
                if (r_tick) begin
                    r_speed_hold   <= speed_shr;
                    r_last_cont    <= n_cont;
                    r_rate_hold    <= rate_prod[15:0];
                    r_loop_counter <= '0;
                end else begin
                    r_loop_counter <= loop_next;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_elec  <= n_elec;
            r_cont  <= n_cont;
            r_reply <= n_reply;
        end
    end

    assign o_out_valid        = r_out_vld;
    assign o_electrical_angle = r_elec;
    assign o_continuous_angle = r_cont;
    assign o_speed_rpm        = r_speed_hold;
    assign o_reply_valid      = r_reply.valid;
    assign o_reply_upper      = r_reply.upper;
    assign o_reply_lower      = r_reply.lower;
    assign o_reply_checksum   = r_reply.checksum;
    assign o_reply_terminator = r_reply.terminator;
    assign o_loop_rate        = r_rate_hold;

endmodule
